FILE: rtl/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
`default_nettype none
package hcb_pkg;
	localparam int MAX_SYMBOLS = 32;
	localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
	localparam int STACK_DEPTH = 32;
	localparam int IDX_W       = $clog2(NODE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int WGT_W       = 21;
	localparam int CODE_W      = 31;
	localparam int LEN_W       = 5;

	typedef enum logic [2:0] {
		S_LOAD, S_MADD, S_MINS, S_ROOT, S_FETCH, S_EXAM, S_POPRD, S_POPLD
	} hcb_state_t;

	typedef struct packed {
		logic load;
		logic madd;
		logic mins;
		logic root;
		logic fetch;
		logic emit;
		logic push;
		logic pop_rd;
		logic pop_ld;
	} hcb_cmd_t;

	typedef struct packed {
		logic cnt_ge2;
		logic is_leaf;
		logic sp_zero;
		logic out_busy;
	} hcb_stat_t;

	typedef struct packed {
		logic             leaf;
		logic [7:0]       sym;
		logic [IDX_W-1:0] c0;
		logic [IDX_W-1:0] c1;
	} hcb_node_t;

	typedef struct packed {
		logic [IDX_W-1:0]  node;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hcb_rec_t;
endpackage
`default_nettype wire

FILE: rtl/hcb_ctrl.sv
// Controller state machine: load, merge, and tree walk sequencing.
`default_nettype none
module hcb_ctrl import hcb_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        final_symbol,
	output logic       in_stall,
	input  hcb_stat_t  stat,
	output hcb_cmd_t   cmd
);
	hcb_state_t state_q, state_d;

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

	// Decide next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (final_symbol) state_d = S_MADD;
				end
			end
			S_MADD: begin
				if (stat.cnt_ge2) begin
					cmd.madd = 1'b1;
					state_d  = S_MINS;
				end else begin
					state_d = S_ROOT;
				end
			end
			S_MINS: begin
				cmd.mins = 1'b1;
				state_d  = S_MADD;
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				state_d  = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_EXAM;
			end
			S_EXAM: begin
				if (stat.is_leaf) begin
					if (!stat.out_busy) begin
						cmd.emit = 1'b1;
						state_d  = stat.sp_zero ? S_LOAD : S_POPRD;
					end
				end else begin
					cmd.push = 1'b1;
					state_d  = S_FETCH;
				end
			end
			S_POPRD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_POPLD;
			end
			S_POPLD: begin
				cmd.pop_ld = 1'b1;
				state_d    = S_FETCH;
			end
			default: state_d = S_LOAD;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/hcb_dp.sv
// Datapath: sorted list cells, node store, walk stack and output register.
`default_nettype none
module hcb_dp import hcb_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [7:0]         symbol,
	input  wire  [15:0]        frequency,
	input  hcb_cmd_t           cmd,
	output hcb_stat_t          stat,
	input  wire                out_stall,
	output logic               out_valid,
	output logic [7:0]         code_symbol,
	output logic [CODE_W-1:0]  code_bits,
	output logic [LEN_W-1:0]   code_length,
	output logic               run_end
);
	// List cells, smallest weight at cell 0
	logic [WGT_W-1:0] cw_q [MAX_SYMBOLS];
	logic [IDX_W-1:0] cn_q [MAX_SYMBOLS];
	logic [MAX_SYMBOLS-1:0] cv_q;
	logic [WGT_W-1:0] sw [MAX_SYMBOLS];
	logic [IDX_W-1:0] sn [MAX_SYMBOLS];
	logic [MAX_SYMBOLS-1:0] sv, q;
	logic [WGT_W-1:0] dw [MAX_SYMBOLS];
	logic [IDX_W-1:0] dn [MAX_SYMBOLS];
	logic [MAX_SYMBOLS-1:0] dv;
	logic [WGT_W-1:0] new_w;
	logic [IDX_W-1:0] new_n;

	logic [CNT_W-1:0] lcnt_q, leaf_q;
	logic [IDX_W-1:0] next_q;
	logic [WGT_W-1:0] w_q;
	logic             full;

	hcb_node_t        nmem [NODE_DEPTH];
	hcb_node_t        nrd_q;
	hcb_rec_t         smem [STACK_DEPTH];
	hcb_rec_t         srd_q;
	hcb_rec_t         cur_q;
	logic [SP_W-1:0]  sp_q;
	logic [SP_W-1:0]  sp_dec;
	logic             out_valid_q;

	assign full   = (leaf_q == CNT_W'(MAX_SYMBOLS));
	assign sp_dec = sp_q - 1'b1;

	// Build next cell contents: shifted source plus one inserted entry
	always_comb begin
		new_w = cmd.mins ? w_q : {{(WGT_W-16){1'b0}}, frequency};
		new_n = cmd.mins ? next_q : leaf_q[IDX_W-1:0];
		for (int k = 0; k < MAX_SYMBOLS - 2; k++) begin
			sw[k] = cmd.mins ? cw_q[k+2] : cw_q[k];
			sn[k] = cmd.mins ? cn_q[k+2] : cn_q[k];
			sv[k] = cmd.mins ? cv_q[k+2] : cv_q[k];
		end
		for (int k = MAX_SYMBOLS - 2; k < MAX_SYMBOLS; k++) begin
			sw[k] = cmd.mins ? '0 : cw_q[k];
			sn[k] = cmd.mins ? '0 : cn_q[k];
			sv[k] = cmd.mins ? 1'b0 : cv_q[k];
		end
		for (int k = 0; k < MAX_SYMBOLS; k++)
			q[k] = sv[k] && (cmd.mins ? (sw[k] <= new_w) : (sw[k] < new_w));
		// Cell 0 keeps its entry or takes the new one
		dw[0] = q[0] ? sw[0] : new_w;
		dn[0] = q[0] ? sn[0] : new_n;
		dv[0] = 1'b1;
		for (int k = 1; k < MAX_SYMBOLS; k++) begin
			if (q[k]) begin
				dw[k] = sw[k];
				dn[k] = sn[k];
				dv[k] = 1'b1;
			end else if (q[k-1]) begin
				dw[k] = new_w;
				dn[k] = new_n;
				dv[k] = 1'b1;
			end else begin
				dw[k] = sw[k-1];
				dn[k] = sn[k-1];
				dv[k] = sv[k-1];
			end
		end
	end

	// Update list cells and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q   <= '0;
			lcnt_q <= '0;
			leaf_q <= '0;
			next_q <= '0;
		end else if ((cmd.load && !full) || cmd.mins) begin
			cv_q <= dv;
			if (cmd.mins) begin
				lcnt_q <= lcnt_q - 1'b1;
				next_q <= next_q + 1'b1;
			end else begin
				lcnt_q <= lcnt_q + 1'b1;
				leaf_q <= leaf_q + 1'b1;
				next_q <= IDX_W'(leaf_q + 1'b1);
			end
		end else if (cmd.root) begin
			cv_q   <= '0;
			lcnt_q <= '0;
			leaf_q <= '0;
		end
	end

	// Hold cell payload
	always_ff @(posedge clk) begin
		if ((cmd.load && !full) || cmd.mins) begin
			for (int k = 0; k < MAX_SYMBOLS; k++) begin
				cw_q[k] <= dw[k];
				cn_q[k] <= dn[k];
			end
		end
		if (cmd.madd) w_q <= cw_q[0] + cw_q[1];
	end

	// Node store: write leaves and merged nodes, registered read
	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			nmem[leaf_q[IDX_W-1:0]] <= '{leaf: 1'b1, sym: symbol, c0: '0, c1: '0};
		else if (cmd.madd)
			nmem[next_q] <= '{leaf: 1'b0, sym: 8'd0, c0: cn_q[0], c1: cn_q[1]};
		if (cmd.fetch) nrd_q <= nmem[cur_q.node];
	end

	// Walk stack memory
	always_ff @(posedge clk) begin
		if (cmd.push)
			smem[sp_q[SP_W-2:0]] <= '{node: nrd_q.c1,
				code: {cur_q.code[CODE_W-2:0], 1'b1}, len: cur_q.len + 1'b1};
		if (cmd.pop_rd) srd_q <= smem[sp_dec[SP_W-2:0]];
	end

	// Current walk record and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.root) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + 1'b1;
		end else if (cmd.pop_rd) begin
			sp_q <= sp_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root)
			cur_q <= '{node: cn_q[0], code: '0, len: '0};
		else if (cmd.push)
			cur_q <= '{node: nrd_q.c0, code: {cur_q.code[CODE_W-2:0], 1'b0},
				len: cur_q.len + 1'b1};
		else if (cmd.pop_ld)
			cur_q <= srd_q;
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_symbol <= nrd_q.sym;
			code_bits   <= cur_q.code;
			code_length <= cur_q.len;
			run_end     <= (sp_q == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.cnt_ge2  = (lcnt_q >= CNT_W'(2));
	assign stat.is_leaf  = nrd_q.leaf;
	assign stat.sp_zero  = (sp_q == '0);
	assign stat.out_busy = out_valid_q && out_stall;
endmodule
`default_nettype wire

FILE: rtl/huffman_code_builder.sv
// Huffman code builder top level: controller plus datapath.
// A non-final item is taken in the load state; the final item starts a build of
// alternating merge-add and merge-insert steps, then a root step and a tree walk; the
// walk pops the stack after each leaf but the last and reads one node store entry per
// step, bounding the rate of sets. Input stalls during build and walk.
// Reset clears the list, counts and output valid; node and stack stores are not cleared.
`default_nettype none
module huffman_code_builder import hcb_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [7:0]         symbol,
	input  wire  [15:0]        frequency,
	input  wire                final_symbol,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [7:0]         code_symbol,
	output logic [CODE_W-1:0]  code_bits,
	output logic [LEN_W-1:0]   code_length,
	output logic               run_end
);
	hcb_cmd_t  cmd;
	hcb_stat_t stat;

	hcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.final_symbol(final_symbol), .in_stall(in_stall), .stat(stat), .cmd(cmd)
	);

	hcb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .symbol(symbol), .frequency(frequency),
		.cmd(cmd), .stat(stat), .out_stall(out_stall), .out_valid(out_valid),
		.code_symbol(code_symbol), .code_bits(code_bits),
		.code_length(code_length), .run_end(run_end)
	);
endmodule
`default_nettype wire

FILE: rtl/hcb_checker.sv
// Port-level checks for the Huffman code builder, bound to the top level.
`default_nettype none
module hcb_checker import hcb_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire               final_symbol,
	input wire               out_valid,
	input wire               out_stall,
	input wire [7:0]         code_symbol,
	input wire [LEN_W-1:0]   code_length,
	input wire               run_end
);
	// Stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_symbol))
		else $error("stalled result item changed");

	// Final item starts the build, so input stalls next
	a_final_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_symbol |=> in_stall)
		else $error("input taken during build");

	// A result that is not the last means the walk is still going
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_end |-> in_stall)
		else $error("input open before the set ended");

	// Zero-length code only for a lone symbol
	a_len0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_length == '0 |-> run_end)
		else $error("zero-length code in a multi-symbol set");
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.final_symbol(final_symbol), .out_valid(out_valid), .out_stall(out_stall),
	.code_symbol(code_symbol), .code_length(code_length), .run_end(run_end)
);
`default_nettype wire
